// ===== rtl/core/sxfb_pkg.sv =====
// sxfb_pkg: shared types, screen constants and sprite mask helper for the
// sprite xor framebuffer. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sxfb_pkg;

  localparam int unsigned ScreenWidth  = 64;
  localparam int unsigned ScreenHeight = 32;
  localparam int unsigned XW           = $clog2(ScreenWidth);
  localparam int unsigned YW           = $clog2(ScreenHeight);
  localparam int unsigned SumW         = $clog2(ScreenHeight + 15);
  localparam int unsigned SpriteW      = 8;
  localparam int unsigned RowPixW      = 64;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_DRAW  = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         x_coord;
    logic [7:0]         y_coord;
    logic [3:0]         row_offset;
    logic [SpriteW-1:0] row_bits;
    logic               last_row;
  } req_t;

  typedef struct packed {
    logic               collision;
    logic               sprite_done;
    logic [RowPixW-1:0] row_pixels;
  } rsp_t;

  typedef struct packed {
    logic          clear;
    logic          draw;
    logic          read;
    logic          we;
    logic [YW-1:0] row_idx;
  } row_op_t;

  // bit 7 of the sprite lands at column x, columns past the edge drop out
  function automatic logic [ScreenWidth-1:0] sprite_mask(logic [XW-1:0] x,
                                                         logic [SpriteW-1:0] bits);
    logic [SpriteW-1:0]             rev;
    logic [ScreenWidth+SpriteW-1:0] wide;
    for (int b = 0; b < SpriteW; b++) begin
      rev[b] = bits[SpriteW-1-b];
    end
    wide = {{ScreenWidth{1'b0}}, rev} << x;
    return wide[ScreenWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sxfb_row_alu.sv =====
// sxfb_row_alu: decodes one request, picks the framebuffer row and computes
// the xor-updated row and collision hit. depends on sxfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sxfb_row_alu (
  input  wire  sxfb_pkg::req_t                      req_i,
  input  wire  logic [sxfb_pkg::ScreenWidth-1:0]    cur_row_i,
  output sxfb_pkg::row_op_t                         op_o,
  output logic [sxfb_pkg::ScreenWidth-1:0]          new_row_o,
  output logic                                      hit_o
);

  logic [sxfb_pkg::SumW-1:0]        row_sum;
  logic                             in_range;
  logic [sxfb_pkg::ScreenWidth-1:0] mask;

  assign row_sum = sxfb_pkg::SumW'(req_i.y_coord % sxfb_pkg::ScreenHeight)
                 + sxfb_pkg::SumW'(req_i.row_offset);
  assign in_range = row_sum < sxfb_pkg::SumW'(sxfb_pkg::ScreenHeight);
  assign mask = sxfb_pkg::sprite_mask(
                  sxfb_pkg::XW'(req_i.x_coord % sxfb_pkg::ScreenWidth), req_i.row_bits);

  always_comb begin
    op_o = '0;
    case (sxfb_pkg::func_e'(req_i.func))
      sxfb_pkg::FUNC_CLEAR: begin
        op_o.clear = 1'b1;
      end
      sxfb_pkg::FUNC_DRAW: begin
        op_o.draw    = 1'b1;
        op_o.we      = in_range;
        op_o.row_idx = row_sum[sxfb_pkg::YW-1:0];
      end
      sxfb_pkg::FUNC_READ: begin
        op_o.read    = 1'b1;
        op_o.row_idx = sxfb_pkg::YW'(req_i.y_coord % sxfb_pkg::ScreenHeight);
      end
      default: begin
        op_o = '0;
      end
    endcase
  end

  assign new_row_o = cur_row_i ^ mask;
  assign hit_o     = op_o.we && ((cur_row_i & mask) != '0);

endmodule

`default_nettype wire

// ===== rtl/core/sprite_xor_framebuffer_top.sv =====
// sprite_xor_framebuffer_top: request register, row update logic, flag and
// result register around the framebuffer. depends on sxfb_pkg, sxfb_row_alu.
// a request is held in the request register, then in the result register.
// throughput: one request per cycle while the output is taken; the request
// register drains into the result register whenever that is empty or being taken.
// reset: asynchronous, clears every pixel, the collision flag and all valids.
`timescale 1ns / 1ps
`default_nettype none

module sprite_xor_framebuffer_top (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            in_valid_i,
  output logic                  in_ready_o,
  input  wire  sxfb_pkg::req_t  in_req_i,
  output logic                  out_valid_o,
  input  wire  logic            out_ready_i,
  output sxfb_pkg::rsp_t        out_rsp_o
);

  sxfb_pkg::req_t                   req_q;
  logic                             s1_valid_q;
  logic                             out_valid_q;
  sxfb_pkg::rsp_t                   rsp_q;
  sxfb_pkg::rsp_t                   rsp_d;
  logic                             accum_q;
  logic                             accum_d;
  logic [sxfb_pkg::ScreenWidth-1:0] frame_q [sxfb_pkg::ScreenHeight];
  logic [sxfb_pkg::ScreenWidth-1:0] cur_row;
  logic [sxfb_pkg::ScreenWidth-1:0] new_row;
  logic                             hit;
  logic                             coll;
  sxfb_pkg::row_op_t                op;
  logic                             accept;
  logic                             s1_adv;
  logic                             frame_any;

  assign accept     = in_valid_i && in_ready_o;
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  assign cur_row = frame_q[op.row_idx];

  sxfb_row_alu u_row_alu (
    .req_i      (req_q),
    .cur_row_i  (cur_row),
    .op_o       (op),
    .new_row_o  (new_row),
    .hit_o      (hit)
  );

  assign coll    = accum_q || hit;
  assign accum_d = req_q.last_row ? 1'b0 : coll;

  always_comb begin
    rsp_d             = '0;
    rsp_d.collision   = op.draw && coll;
    rsp_d.sprite_done = op.draw && req_q.last_row;
    if (op.read) begin
      rsp_d.row_pixels = 64'(cur_row);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= 1'b0;
    end else if (s1_adv && op.draw) begin
      accum_q <= accum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sxfb_pkg::ScreenHeight; i++) begin
        frame_q[i] <= '0;
      end
    end else if (s1_adv) begin
      if (op.clear) begin
        for (int i = 0; i < sxfb_pkg::ScreenHeight; i++) begin
          frame_q[i] <= '0;
        end
      end else if (op.we) begin
        frame_q[op.row_idx] <= new_row;
      end
    end
  end

  always_comb begin
    frame_any = 1'b0;
    for (int i = 0; i < sxfb_pkg::ScreenHeight; i++) begin
      frame_any = frame_any || (frame_q[i] != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // stalls only when both stages are full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("request side stalled without backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && op.draw && req_q.last_row) |=> !accum_q)
    else $error("collision flag not cleared at end of sprite");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && op.clear) |=> !frame_any)
    else $error("framebuffer not blank after clear");

endmodule

`default_nettype wire
